/* sv/npf_pkg.sv */
// ----------------------------------------------------------------------------
// npf_pkg: shared types for the next prime finder
// Sequencer state codes and the status bundle of the bit-serial remainder unit.
// ----------------------------------------------------------------------------
package npf_pkg;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_TEST  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_NEXT  = 6'b010000,
    ST_DONE  = 6'b100000
  } npf_state_e;

  // Remainder unit status towards the sequencer
  typedef struct packed {
    logic busy;  // division in progress
    logic done;  // one-cycle pulse, remainder valid
    logic zero;  // remainder is zero (valid with done)
  } npf_rem_sts_t;

endpackage

/* sv/npf_rem.sv */
// ----------------------------------------------------------------------------
// npf_rem: bit-serial remainder unit
// Restoring division, one dividend bit per cycle from the MSB down; only the
// remainder is kept. Done pulses once the last dividend bit has been taken in.
// ----------------------------------------------------------------------------
module npf_rem #(
  parameter int DATA_WIDTH = 32,
  parameter int DIV_WIDTH  = 18
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DATA_WIDTH-1:0]   dividend_i,
  input  logic [DIV_WIDTH-1:0]    divisor_i,
  output npf_pkg::npf_rem_sts_t   sts_o
);
  import npf_pkg::*;

  localparam int CntW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] sh_q, sh_d;
  logic [DIV_WIDTH-1:0]  rem_q, rem_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_WIDTH:0]    trial;
  logic [DIV_WIDTH:0]    diff;

  // One restoring step: bring in the next bit, subtract if it fits
  assign trial = {rem_q, sh_q[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      sh_d  = {sh_q[DATA_WIDTH-2:0], 1'b0};
      rem_d = (trial >= {1'b0, divisor_i}) ? diff[DIV_WIDTH-1:0]
                                           : trial[DIV_WIDTH-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      sh_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(DATA_WIDTH);
      busy_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign sts_o.zero = (rem_q == '0);

endmodule

/* sv/next_prime_finder.sv */
// ----------------------------------------------------------------------------
// next_prime_finder: smallest prime at or above a signed start value
// Trial division by 2, 3 and then 5, 7, 11, 13, ... while d*d <= candidate.
// ----------------------------------------------------------------------------
// Usage:
//   Input item on s_axis: tdata carries start_value (signed). Any value below
//   two gives two. Output item on m_axis: tdata carries next_prime.
//   One item is searched at a time; s_axis_tready_o is high only while the
//   sequencer is idle. A found prime goes to an output register, so the next
//   item can be taken while the result waits for m_axis_tready_i.
// Search:
//   Each trial division runs in the bit-serial remainder unit. An odd
//   candidate above 3 takes one division by 3 and one by each odd divisor
//   not divisible by 3 up to its square root, plus sequencing; composites
//   stop at their first factor. Total time is the sum over all candidates
//   tried.
// Reset:
//   Asynchronous, active low; the block returns to idle with no result held.
//   A stalled receiver holds the result; a further prime waits in the
//   sequencer until the output register is free.
// ----------------------------------------------------------------------------
module next_prime_finder #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [DATA_WIDTH-1:0] start_value, zero padding above
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [DATA_WIDTH-2:0] next_prime, zero padding above
  output logic [((DATA_WIDTH+6)/8)*8-1:0]       m_axis_tdata_o
);
  import npf_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int DW    = (W + 1) / 2 + 2;
  localparam int SW    = W + 2;
  localparam int OutTw = ((W + 6) / 8) * 8;

  npf_state_e      state_q, state_d;
  logic [W-1:0]    cand_q, cand_d;
  logic [DW-1:0]   div_q, div_d;
  logic [SW-1:0]   sq_q, sq_d;
  logic            step4_q, step4_d;
  logic [W-2:0]    out_q, out_d;
  logic            out_vld_q, out_vld_d;
  logic            div_start;
  logic            in_acc;
  logic [W-1:0]    in_val;
  npf_rem_sts_t    rem_sts;

  npf_rem #(
    .DATA_WIDTH (W),
    .DIV_WIDTH  (DW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cand_q),
    .divisor_i  (div_q),
    .sts_o      (rem_sts)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_val          = s_axis_tdata_i[W-1:0];

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cand_d    = cand_q;
    div_d     = div_q;
    sq_d      = sq_q;
    step4_d   = step4_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    div_start = 1'b0;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // negative, zero or one starts the search at two
          if (in_val[W-1] || (in_val < W'(2))) begin
            cand_d = W'(2);
          end else begin
            cand_d = in_val;
          end
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if ((cand_q == W'(2)) || (cand_q == W'(3))) begin
          state_d = ST_DONE;
        end else if (!cand_q[0]) begin
          state_d = ST_NEXT;
        end else begin
          div_d     = DW'(3);
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_sts.done) begin
          if (rem_sts.zero) begin
            state_d = ST_NEXT;
          end else begin
            // divisors 5, 7, 11, 13, ... with their squares kept alongside
            if (div_q == DW'(3)) begin
              div_d   = DW'(5);
              sq_d    = SW'(25);
              step4_d = 1'b0;
            end else if (step4_q) begin
              div_d   = div_q + DW'(4);
              sq_d    = sq_q + (SW'(div_q) << 3) + SW'(16);
              step4_d = 1'b0;
            end else begin
              div_d   = div_q + DW'(2);
              sq_d    = sq_q + (SW'(div_q) << 2) + SW'(4);
              step4_d = 1'b1;
            end
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_q > SW'(cand_q)) begin
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_NEXT: begin
        cand_d  = cand_q + W'(1);
        state_d = ST_TEST;
      end
      ST_DONE: begin
        // wait for a free output register
        if (!out_vld_q || m_axis_tready_i) begin
          out_d     = cand_q[W-2:0];
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    step4_q <= step4_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OutTw'(out_q);

endmodule
